>>> hdl/pac_pkg.sv
package pac_pkg;

   // widths of the item and register fields
   localparam int POS_W   = 16;
   localparam int ACC_W   = 32;
   localparam int WORD_W  = 64;
   localparam int FIELD_W = 16;
   localparam int COUNT_W = 3;
   localparam int IDX_W   = 3;

   // arithmetic widths: offset, squared length, pull numerator and quotient
   localparam int OFS_W = POS_W + 1;
   localparam int MAG_W = POS_W;
   localparam int SQ_W  = 2 * MAG_W;
   localparam int DEN_W = SQ_W + 2;
   localparam int NUM_W = SQ_W + 16;

   // lane count default
   localparam int MAX_ATTRACTORS_DEF = 4;

   // register indexes
   localparam logic [IDX_W-1:0] REG_COUNT     = 3'd0;
   localparam logic [IDX_W-1:0] REG_WORD0     = 3'd1;
   localparam int               NUM_WORD_REGS = 4;

   // q16.16 limits
   localparam logic [ACC_W-1:0] ACC_MAX = 32'h7FFF_FFFF;
   localparam logic [ACC_W-1:0] ACC_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
      logic [ACC_W-1:0] accel_x;
      logic [ACC_W-1:0] accel_y;
      logic [ACC_W-1:0] accel_z;
      logic             last_in;
   } req_item_type;

   typedef struct packed {
      logic [ACC_W-1:0] new_accel_x;
      logic [ACC_W-1:0] new_accel_y;
      logic [ACC_W-1:0] new_accel_z;
      logic             coincident_flag;
      logic             saturated_flag;
      logic             last_out;
   } rsp_item_type;

endpackage

>>> hdl/pac_if.sv
interface pac_req_if;
   logic                          valid;
   logic                          ready;
   logic signed [pac_pkg::POS_W-1:0] pos_x;
   logic signed [pac_pkg::POS_W-1:0] pos_y;
   logic signed [pac_pkg::POS_W-1:0] pos_z;
   logic signed [pac_pkg::ACC_W-1:0] accel_x;
   logic signed [pac_pkg::ACC_W-1:0] accel_y;
   logic signed [pac_pkg::ACC_W-1:0] accel_z;
   logic                          last_in;
   modport source (output valid, pos_x, pos_y, pos_z, accel_x, accel_y, accel_z, last_in,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, accel_x, accel_y, accel_z, last_in,
                 output ready);
endinterface

interface pac_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [pac_pkg::ACC_W-1:0] new_accel_x;
   logic signed [pac_pkg::ACC_W-1:0] new_accel_y;
   logic signed [pac_pkg::ACC_W-1:0] new_accel_z;
   logic                          coincident_flag;
   logic                          saturated_flag;
   logic                          last_out;
   modport source (output valid, new_accel_x, new_accel_y, new_accel_z, coincident_flag,
                   saturated_flag, last_out, input ready);
   modport sink (input valid, new_accel_x, new_accel_y, new_accel_z, coincident_flag,
                 saturated_flag, last_out, output ready);
endinterface

interface pac_csr_if;
   logic                           valid;
   logic                           ready;
   logic [pac_pkg::IDX_W-1:0]      reg_index;
   logic [pac_pkg::WORD_W-1:0]     wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> hdl/point_attractor_accumulator.sv
// Point attractor accumulator: one particle item in, one item out, at one item
// per clock. Each item's acceleration gains offset * strength / squared length
// for every enabled attractor (attractor count register, capped at
// MAX_ATTRACTORS); an attractor at zero distance adds nothing and raises
// coincident_flag. The per-axis sum saturates to Q16.16 and raises
// saturated_flag. Each lane and axis has a 48-stage restoring divider. The
// whole pipe stalls while a result waits unaccepted; the user must write
// configuration only while no item is in flight, as the block itself does
// not enforce it.
module point_attractor_accumulator #(
   parameter int MAX_ATTRACTORS = pac_pkg::MAX_ATTRACTORS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pac_req_if.sink    req_ch,
   pac_rsp_if.source  rsp_ch,
   pac_csr_if.sink    csr_ch
);

   localparam int FRONT_LAT = 3;
   localparam int DIV_LAT   = pac_pkg::NUM_W;
   localparam int SUM_W     = pac_pkg::NUM_W + $clog2(MAX_ATTRACTORS + 1);

   typedef struct packed {
      logic [2:0][pac_pkg::ACC_W-1:0] acc;
      logic                           last;
   } front_type;

   typedef struct packed {
      logic [2:0][pac_pkg::ACC_W-1:0]     acc;
      logic                               last;
      logic                               coin;
      logic [MAX_ATTRACTORS-1:0]          keep;
      logic [MAX_ATTRACTORS-1:0][2:0]     neg;
   } div_side_type;

   typedef struct packed {
      logic [2:0][SUM_W-1:0]                          sum;
      logic [MAX_ATTRACTORS-1:0][2:0][pac_pkg::NUM_W-1:0] term;
      logic                                           coin;
      logic                                           last;
   } acc_type;

   logic                                               en;
   pac_pkg::req_item_type                              in_ff;
   logic                                               in_v_ff;
   logic [MAX_ATTRACTORS-1:0][pac_pkg::WORD_W-1:0]     words;
   logic [MAX_ATTRACTORS-1:0]                          lane_en;
   logic [MAX_ATTRACTORS-1:0][2:0][pac_pkg::NUM_W-1:0] lane_num;
   logic [MAX_ATTRACTORS-1:0][pac_pkg::DEN_W-1:0]      lane_den;
   logic [MAX_ATTRACTORS-1:0][2:0]                     lane_neg;
   logic [MAX_ATTRACTORS-1:0]                          lane_keep;
   logic [MAX_ATTRACTORS-1:0]                          lane_coin;
   logic [MAX_ATTRACTORS-1:0][2:0][pac_pkg::NUM_W-1:0] quo;
   front_type                                          fr_ff [FRONT_LAT];
   logic [FRONT_LAT-1:0]                               fr_v_ff;
   div_side_type                                       dv_in;
   div_side_type                                       dv_ff [DIV_LAT];
   logic [DIV_LAT-1:0]                                 dv_v_ff;
   acc_type                                            ac_in;
   acc_type                                            ac_ff [MAX_ATTRACTORS+1];
   logic [MAX_ATTRACTORS:0]                            ac_v_ff;
   pac_pkg::rsp_item_type                              out_in;
   pac_pkg::rsp_item_type                              out_ff;
   logic                                               out_v_ff;

   // the whole pipe moves unless a result is held
   assign en = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   pac_regs #(.MAX_ATTRACTORS(MAX_ATTRACTORS)) u_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .words   (words),
      .lane_en (lane_en)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff.pos_x   <= req_ch.pos_x;
         in_ff.pos_y   <= req_ch.pos_y;
         in_ff.pos_z   <= req_ch.pos_z;
         in_ff.accel_x <= req_ch.accel_x;
         in_ff.accel_y <= req_ch.accel_y;
         in_ff.accel_z <= req_ch.accel_z;
         in_ff.last_in <= req_ch.last_in;
      end
   end

   // attractor lanes and their dividers
   for (genvar a = 0; a < MAX_ATTRACTORS; a++) begin : g_lane
      pac_lane u_lane (
         .clock   (clock),
         .enable  (en),
         .pos_x   (in_ff.pos_x),
         .pos_y   (in_ff.pos_y),
         .pos_z   (in_ff.pos_z),
         .word    (words[a]),
         .lane_en (lane_en[a]),
         .num     (lane_num[a]),
         .den     (lane_den[a]),
         .neg     (lane_neg[a]),
         .keep    (lane_keep[a]),
         .coin    (lane_coin[a])
      );
      for (genvar k = 0; k < 3; k++) begin : g_axis
         pac_div #(.NUM_W(pac_pkg::NUM_W), .DEN_W(pac_pkg::DEN_W)) u_div (
            .clock   (clock),
            .enable  (en),
            .num_in  (lane_num[a][k]),
            .den_in  (lane_den[a]),
            .quo_out (quo[a][k])
         );
      end
   end

   // side data alongside the lane front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         fr_v_ff <= '0;
      end else if (en) begin
         fr_v_ff <= {fr_v_ff[FRONT_LAT-2:0], in_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fr_ff[0].acc  <= {in_ff.accel_z, in_ff.accel_y, in_ff.accel_x};
         fr_ff[0].last <= in_ff.last_in;
         for (int i = 1; i < FRONT_LAT; i++) begin
            fr_ff[i] <= fr_ff[i-1];
         end
      end
   end

   // side data alongside the dividers
   always_comb begin
      dv_in.acc  = fr_ff[FRONT_LAT-1].acc;
      dv_in.last = fr_ff[FRONT_LAT-1].last;
      dv_in.coin = |lane_coin;
      dv_in.keep = lane_keep;
      dv_in.neg  = lane_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff <= '0;
      end else if (en) begin
         dv_v_ff <= {dv_v_ff[DIV_LAT-2:0], fr_v_ff[FRONT_LAT-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= dv_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
      end
   end

   // signed terms and the starting sums
   always_comb begin
      ac_in.coin = dv_ff[DIV_LAT-1].coin;
      ac_in.last = dv_ff[DIV_LAT-1].last;
      for (int k = 0; k < 3; k++) begin
         ac_in.sum[k] = {{(SUM_W-pac_pkg::ACC_W){dv_ff[DIV_LAT-1].acc[k][pac_pkg::ACC_W-1]}},
                         dv_ff[DIV_LAT-1].acc[k]};
      end
      for (int a = 0; a < MAX_ATTRACTORS; a++) begin
         for (int k = 0; k < 3; k++) begin
            if (!dv_ff[DIV_LAT-1].keep[a]) begin
               ac_in.term[a][k] = '0;
            end else if (dv_ff[DIV_LAT-1].neg[a][k]) begin
               ac_in.term[a][k] = -quo[a][k];
            end else begin
               ac_in.term[a][k] = quo[a][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ac_v_ff <= '0;
      end else if (en) begin
         ac_v_ff <= {ac_v_ff[MAX_ATTRACTORS-1:0], dv_v_ff[DIV_LAT-1]};
      end
   end

   // one attractor term added per stage
   always_ff @(posedge clock) begin
      if (en) begin
         ac_ff[0] <= ac_in;
         for (int a = 0; a < MAX_ATTRACTORS; a++) begin
            ac_ff[a+1].term <= ac_ff[a].term;
            ac_ff[a+1].coin <= ac_ff[a].coin;
            ac_ff[a+1].last <= ac_ff[a].last;
            for (int k = 0; k < 3; k++) begin
               ac_ff[a+1].sum[k] <= ac_ff[a].sum[k] +
                  {{(SUM_W-pac_pkg::NUM_W){ac_ff[a].term[a][k][pac_pkg::NUM_W-1]}},
                   ac_ff[a].term[a][k]};
            end
         end
      end
   end

   // saturation to q16.16
   always_comb begin
      logic [2:0][pac_pkg::ACC_W-1:0] res;
      logic [2:0]                     clip;
      for (int k = 0; k < 3; k++) begin
         clip[k] = !(&ac_ff[MAX_ATTRACTORS].sum[k][SUM_W-1:pac_pkg::ACC_W-1]) &&
                   (|ac_ff[MAX_ATTRACTORS].sum[k][SUM_W-1:pac_pkg::ACC_W-1]);
         if (!clip[k]) begin
            res[k] = ac_ff[MAX_ATTRACTORS].sum[k][pac_pkg::ACC_W-1:0];
         end else if (ac_ff[MAX_ATTRACTORS].sum[k][SUM_W-1]) begin
            res[k] = pac_pkg::ACC_MIN;
         end else begin
            res[k] = pac_pkg::ACC_MAX;
         end
      end
      out_in.new_accel_x     = res[0];
      out_in.new_accel_y     = res[1];
      out_in.new_accel_z     = res[2];
      out_in.coincident_flag = ac_ff[MAX_ATTRACTORS].coin;
      out_in.saturated_flag  = |clip;
      out_in.last_out        = ac_ff[MAX_ATTRACTORS].last;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= ac_v_ff[MAX_ATTRACTORS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid           = out_v_ff;
   assign rsp_ch.new_accel_x     = out_ff.new_accel_x;
   assign rsp_ch.new_accel_y     = out_ff.new_accel_y;
   assign rsp_ch.new_accel_z     = out_ff.new_accel_z;
   assign rsp_ch.coincident_flag = out_ff.coincident_flag;
   assign rsp_ch.saturated_flag  = out_ff.saturated_flag;
   assign rsp_ch.last_out        = out_ff.last_out;

endmodule

>>> hdl/pac_regs.sv
module pac_regs #(
   parameter int MAX_ATTRACTORS = pac_pkg::MAX_ATTRACTORS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   pac_csr_if.sink                                         csr_ch,
   output logic [MAX_ATTRACTORS-1:0][pac_pkg::WORD_W-1:0]  words,
   output logic [MAX_ATTRACTORS-1:0]                       lane_en
);

   logic [pac_pkg::COUNT_W-1:0]                      count_ff;
   logic [MAX_ATTRACTORS-1:0][pac_pkg::WORD_W-1:0]   words_ff;
   logic                                             wr;

   assign csr_ch.ready = 1'b1;
   assign wr = csr_ch.valid;

   // attractor count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (wr && csr_ch.reg_index == pac_pkg::REG_COUNT) begin
         count_ff <= csr_ch.wdata[pac_pkg::COUNT_W-1:0];
      end
   end

   // attractor words, only those with a register index
   for (genvar a = 0; a < MAX_ATTRACTORS; a++) begin : g_word
      always_ff @(posedge clock) begin
         if (reset) begin
            words_ff[a] <= '0;
         end else if (wr && a < pac_pkg::NUM_WORD_REGS &&
                      csr_ch.reg_index == pac_pkg::REG_WORD0 + pac_pkg::IDX_W'(a)) begin
            words_ff[a] <= csr_ch.wdata;
         end
      end
      // a count above the lane count enables every lane
      assign lane_en[a] = (pac_pkg::COUNT_W'(a) < count_ff);
   end

   assign words = words_ff;

endmodule

>>> hdl/pac_lane.sv
module pac_lane (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic [pac_pkg::POS_W-1:0]            pos_x,
   input  logic [pac_pkg::POS_W-1:0]            pos_y,
   input  logic [pac_pkg::POS_W-1:0]            pos_z,
   input  logic [pac_pkg::WORD_W-1:0]           word,
   input  logic                                 lane_en,
   output logic [2:0][pac_pkg::NUM_W-1:0]       num,
   output logic [pac_pkg::DEN_W-1:0]            den,
   output logic [2:0]                           neg,
   output logic                                 keep,
   output logic                                 coin
);

   logic [2:0][pac_pkg::POS_W-1:0]     pos;
   logic [2:0][pac_pkg::OFS_W-1:0]     ofs_ff;
   logic [pac_pkg::FIELD_W-1:0]        str_ff;
   logic                               en2_ff;
   logic [2:0][pac_pkg::SQ_W-1:0]      sq_ff;
   logic [2:0][pac_pkg::SQ_W-1:0]      prod_ff;
   logic [2:0]                         neg3_ff;
   logic                               en3_ff;
   logic [pac_pkg::DEN_W-1:0]          den_ff;
   logic [2:0][pac_pkg::NUM_W-1:0]     num_ff;
   logic [2:0]                         neg4_ff;
   logic                               en4_ff;
   logic [2:0][pac_pkg::MAG_W-1:0]     omag;
   logic [pac_pkg::MAG_W-1:0]          smag;

   assign pos = {pos_z, pos_y, pos_x};

   // offsets from particle to attractor
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            ofs_ff[k] <= {word[16*k+15], word[16*k +: 16]} - {pos[k][15], pos[k]};
         end
         str_ff <= word[63:48];
         en2_ff <= lane_en;
      end
   end

   // magnitudes, then squares and pull products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         omag[k] = ofs_ff[k][pac_pkg::OFS_W-1] ? pac_pkg::MAG_W'(-ofs_ff[k])
                                               : pac_pkg::MAG_W'(ofs_ff[k]);
      end
      smag = str_ff[pac_pkg::FIELD_W-1] ? -str_ff : str_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k]   <= pac_pkg::SQ_W'(omag[k]) * pac_pkg::SQ_W'(omag[k]);
            prod_ff[k] <= pac_pkg::SQ_W'(omag[k]) * pac_pkg::SQ_W'(smag);
            neg3_ff[k] <= ofs_ff[k][pac_pkg::OFS_W-1] ^ str_ff[pac_pkg::FIELD_W-1];
         end
         en3_ff <= en2_ff;
      end
   end

   // squared length and scaled numerators
   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff <= pac_pkg::DEN_W'(sq_ff[0]) + pac_pkg::DEN_W'(sq_ff[1]) +
                   pac_pkg::DEN_W'(sq_ff[2]);
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= {prod_ff[k], 16'h0000};
         end
         neg4_ff <= neg3_ff;
         en4_ff  <= en3_ff;
      end
   end

   assign num  = num_ff;
   assign den  = den_ff;
   assign neg  = neg4_ff;
   assign keep = en4_ff && den_ff != '0;
   assign coin = en4_ff && den_ff == '0;

endmodule

>>> hdl/pac_div.sv
module pac_div #(
   parameter int NUM_W = pac_pkg::NUM_W,
   parameter int DEN_W = pac_pkg::DEN_W
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic [NUM_W-1:0] quo_out
);

   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < NUM_W; j++) begin : g_stage
      logic [NUM_W-1:0] num_p;
      logic [NUM_W-1:0] quo_p;
      logic [DEN_W-1:0] rem_p;
      logic [DEN_W-1:0] den_p;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;

      if (j == 0) begin : g_first
         assign num_p = num_in;
         assign quo_p = '0;
         assign rem_p = '0;
         assign den_p = den_in;
      end else begin : g_next
         assign num_p = num_ff[j-1];
         assign quo_p = quo_ff[j-1];
         assign rem_p = rem_ff[j-1];
         assign den_p = den_ff[j-1];
      end

      assign trial = {rem_p, num_p[NUM_W-1]};
      assign diff  = trial - {1'b0, den_p};
      assign ge    = trial >= {1'b0, den_p};

      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff[j] <= {num_p[NUM_W-2:0], 1'b0};
            quo_ff[j] <= {quo_p[NUM_W-2:0], ge};
            rem_ff[j] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            den_ff[j] <= den_p;
         end
      end
   end

   assign quo_out = quo_ff[NUM_W-1];

endmodule
